// File: rtl/assert_macros.svh
// assertion helpers, clocked on the rising edge and held off during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

// File: rtl/skf_pkg.sv
package skf_pkg;

	localparam int FRAC_BITS = 16;
	localparam int GAIN_BITS = 16;
	localparam int DATA_W    = 32;
	localparam int NOISE_W   = 31;
	localparam int DEN_W     = DATA_W + 1;
	localparam int REM_W     = DATA_W + 2;
	localparam int GAIN_W    = GAIN_BITS + 1;
	localparam int ALU_W     = DATA_W + GAIN_BITS + 2;
	localparam int CNT_W     = $clog2(GAIN_W);

	localparam logic [DATA_W-1:0]  COV_RESET = DATA_W'(1) << FRAC_BITS;
	localparam logic [GAIN_W-1:0]  GAIN_ONE  = GAIN_W'(1) << GAIN_BITS;
	localparam logic [CNT_W-1:0]   LAST_BIT  = CNT_W'(GAIN_BITS);
	localparam logic [NOISE_W-1:0] PROCESS_NOISE_RESET     = NOISE_W'(65536);
	localparam logic [NOISE_W-1:0] MEASUREMENT_NOISE_RESET = NOISE_W'(983040);

	typedef logic [0:0] cfg_idx_t;
	localparam cfg_idx_t REG_PROCESS_NOISE     = 1'b0;
	localparam cfg_idx_t REG_MEASUREMENT_NOISE = 1'b1;

	typedef struct packed {
		logic [NOISE_W-1:0] process_noise;
		logic [NOISE_W-1:0] measurement_noise;
	} skf_cfg_t;

	typedef struct packed {
		logic [ALU_W-1:0] a;
		logic [ALU_W-1:0] b;
		logic             sub;
	} skf_alu_op_t;

endpackage

// File: rtl/scalar_kalman_filter_unit.sv
// channel     dir  handshake                     payload
// s_axis      in   s_axis_tvalid/s_axis_tready   tdata: measurement
// m_axis      out  m_axis_tvalid/m_axis_tready   tdata: estimate
// cfg         in   cfg_valid/cfg_ready           cfg_index, cfg_data
//
// One word is taken at a time, only while the core is idle; the steps run on the shared
// adder: 17 divide steps for the gain, 17 shift-add steps each for the two products.
// The result is held in an output register.
// A stalled result holds the unit in its last step; cfg is always ready.
// After reset: estimate 0, covariance 1.0, noise registers at their defaults.
module scalar_kalman_filter_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [skf_pkg::DATA_W-1:0]      s_axis_tdata,   // [31:0] measurement
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [skf_pkg::DATA_W-1:0]      m_axis_tdata,   // [31:0] estimate
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  skf_pkg::cfg_idx_t               cfg_index,
	input  logic [skf_pkg::DATA_W-1:0]      cfg_data
);
	import skf_pkg::*;

	skf_cfg_t cfg_q;
	logic     core_idle;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.process_noise     <= PROCESS_NOISE_RESET;
			cfg_q.measurement_noise <= MEASUREMENT_NOISE_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_PROCESS_NOISE:     cfg_q.process_noise     <= cfg_data[NOISE_W-1:0];
				REG_MEASUREMENT_NOISE: cfg_q.measurement_noise <= cfg_data[NOISE_W-1:0];
				default: ;
			endcase
		end
	end

	assign s_axis_tready = core_idle;

	skf_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (s_axis_tvalid),
		.meas      (s_axis_tdata),
		.cfg       (cfg_q),
		.idle      (core_idle),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata)
	);

endmodule

// File: rtl/skf_alu.sv
module skf_alu (
	input  skf_pkg::skf_alu_op_t       op,
	output logic [skf_pkg::ALU_W-1:0]  sum,
	output logic                       carry
);
	import skf_pkg::*;

	logic [ALU_W:0] full;

	// carry out of a subtract is set when a >= b (unsigned)
	assign full  = {1'b0, op.a} + {1'b0, op.b ^ {ALU_W{op.sub}}} + {{ALU_W{1'b0}}, op.sub};
	assign sum   = full[ALU_W-1:0];
	assign carry = full[ALU_W];

endmodule

// File: rtl/skf_core.sv
module skf_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [skf_pkg::DATA_W-1:0]   meas,
	input  skf_pkg::skf_cfg_t            cfg,
	output logic                         idle,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [skf_pkg::DATA_W-1:0]   out_data
);
	import skf_pkg::*;

	`include "assert_macros.svh"

	typedef enum logic [3:0] {
		S_IDLE, S_PRED, S_DEN, S_INNOV, S_DIV, S_GAIN,
		S_MUL_X, S_EST, S_MUL_P, S_COV, S_DONE
	} state_t;

	state_t             state_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [DATA_W-1:0]  est_q;
	logic [DATA_W-1:0]  cov_q;
	logic               out_valid_q;
	logic [DATA_W-1:0]  out_data_q;

	logic [DATA_W-1:0]  meas_q;
	logic [DATA_W-1:0]  p_q;
	logic [DEN_W-1:0]   den_q;
	logic [REM_W-1:0]   rem_q;
	logic [GAIN_W-1:0]  k_q;
	logic [GAIN_W-1:0]  gk_q;
	logic [GAIN_W-1:0]  mplier_q;
	logic [ALU_W-1:0]   mcand_q;
	logic [ALU_W-1:0]   acc_q;

	skf_alu_op_t        alu_op;
	logic [ALU_W-1:0]   alu_sum;
	logic               alu_carry;
	logic [REM_W-1:0]   div_trial;
	logic [GAIN_W-1:0]  k_fin;
	logic               out_free;

	skf_alu u_alu (
		.op    (alu_op),
		.sum   (alu_sum),
		.carry (alu_carry)
	);

	assign div_trial = (cnt_q == LAST_BIT) ? rem_q : {rem_q[REM_W-2:0], 1'b0};
	assign k_fin     = (den_q == '0) ? GAIN_ONE : k_q;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		alu_op = '0;
		case (state_q)
			S_PRED: begin
				alu_op.a = ALU_W'(cov_q);
				alu_op.b = ALU_W'(cfg.process_noise);
			end
			S_DEN: begin
				alu_op.a = ALU_W'(p_q);
				alu_op.b = ALU_W'(cfg.measurement_noise);
			end
			S_INNOV: begin
				alu_op.a   = {{(ALU_W-DATA_W){meas_q[DATA_W-1]}}, meas_q};
				alu_op.b   = {{(ALU_W-DATA_W){est_q[DATA_W-1]}}, est_q};
				alu_op.sub = 1'b1;
			end
			S_DIV: begin
				alu_op.a   = ALU_W'(div_trial);
				alu_op.b   = ALU_W'(den_q);
				alu_op.sub = 1'b1;
			end
			S_GAIN: begin
				alu_op.a   = ALU_W'(GAIN_ONE);
				alu_op.b   = ALU_W'(k_fin);
				alu_op.sub = 1'b1;
			end
			S_MUL_X, S_MUL_P: begin
				alu_op.a = acc_q;
				alu_op.b = mplier_q[0] ? mcand_q : '0;
			end
			S_EST: begin
				// floor of acc / 2^GAIN_BITS
				alu_op.a = {{(ALU_W-DATA_W){est_q[DATA_W-1]}}, est_q};
				alu_op.b = {{GAIN_BITS{acc_q[ALU_W-1]}}, acc_q[ALU_W-1:GAIN_BITS]};
			end
			default: alu_op = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			est_q       <= '0;
			cov_q       <= COV_RESET;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
		end else begin
			if (state_q == S_DONE && out_free)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start)
						state_q <= S_PRED;
				end
				S_PRED:  state_q <= S_DEN;
				S_DEN:   state_q <= S_INNOV;
				S_INNOV: begin
					cnt_q   <= LAST_BIT;
					state_q <= S_DIV;
				end
				S_DIV: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0)
						state_q <= S_GAIN;
				end
				S_GAIN: begin
					cnt_q   <= LAST_BIT;
					state_q <= S_MUL_X;
				end
				S_MUL_X: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0)
						state_q <= S_EST;
				end
				S_EST: begin
					est_q   <= alu_sum[DATA_W-1:0];
					cnt_q   <= LAST_BIT;
					state_q <= S_MUL_P;
				end
				S_MUL_P: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0)
						state_q <= S_COV;
				end
				S_COV: begin
					cov_q   <= acc_q[DATA_W+GAIN_BITS-1:GAIN_BITS];
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						out_data_q  <= est_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (start)
					meas_q <= meas;
			end
			S_PRED: p_q <= alu_sum[DATA_W] ? '1 : alu_sum[DATA_W-1:0];
			S_DEN: begin
				den_q <= alu_sum[DEN_W-1:0];
				rem_q <= REM_W'(p_q);
			end
			S_INNOV: mcand_q <= alu_sum;
			S_DIV: begin
				rem_q <= alu_carry ? alu_sum[REM_W-1:0] : div_trial;
				k_q   <= {k_q[GAIN_W-2:0], alu_carry};
			end
			S_GAIN: begin
				k_q      <= k_fin;
				gk_q     <= alu_sum[GAIN_W-1:0];
				mplier_q <= k_fin;
				acc_q    <= '0;
			end
			S_MUL_X, S_MUL_P: begin
				acc_q    <= alu_sum;
				mcand_q  <= {mcand_q[ALU_W-2:0], 1'b0};
				mplier_q <= {1'b0, mplier_q[GAIN_W-1:1]};
			end
			S_EST: begin
				mcand_q  <= ALU_W'(p_q);
				mplier_q <= gk_q;
				acc_q    <= '0;
			end
			default: ;
		endcase
	end

	assign idle      = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	`ASSERT_NEXT(a_start_leaves_idle, clk, arst_n, start && state_q == S_IDLE, state_q == S_PRED)
	`ASSERT_SAME(a_gain_bounded, clk, arst_n, state_q == S_MUL_X, k_q <= GAIN_ONE)
	`ASSERT_SAME(a_cov_not_grown, clk, arst_n, state_q == S_COV, acc_q[ALU_W-1:GAIN_BITS] <= (ALU_W-GAIN_BITS)'(p_q))
	`ASSERT_NEXT(a_done_posts_word, clk, arst_n, state_q == S_DONE && out_free, out_valid_q && state_q == S_IDLE)

endmodule
